// ----- rtl/llt_pkg.sv -----
// ----------------------------------------------------------------------------
// llt_pkg: shared types and constants for laser line triangulation
// Fixed-point formats, datapath widths, request/result structs, the
// sequencer state codes and the micro-step codes of the Cramer solver.
// ----------------------------------------------------------------------------
package llt_pkg;

  // Field formats
  localparam int PIXEL_BITS = 12;
  localparam int FRAC_BITS  = 16;
  localparam int COEF_W     = 32;
  localparam int COORD_W    = 40;
  localparam int RHS_W      = 56;

  // Configuration port
  localparam int CFG_W     = 64;
  localparam int NUM_CFG   = 6;
  localparam int NUM_COEF  = 2 * NUM_CFG;
  localparam int CFG_IDX_W = $clog2(NUM_CFG);

  // Datapath widths
  // linear term M*w - M, exact
  localparam int LIN_W    = COEF_W + PIXEL_BITS + 1;
  localparam int MCAND_W  = RHS_W;
  localparam int MPLIER_W = LIN_W;
  localparam int PROD_W   = MCAND_W + MPLIER_W;
  // difference of two products, signed
  localparam int NUM_W    = PROD_W + 2;
  // multiplier digit, bits consumed per cycle
  localparam int DIG_W    = 4;
  // numerator bits shifted into the divider after the overflow check
  localparam int QLO_W    = COORD_W - FRAC_BITS;
  localparam int DCNT_W   = $clog2(COORD_W);

  // Saturation limits
  localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W - 1){1'b0}}};
  localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W - 1){1'b1}}};
  localparam logic [RHS_W-1:0]   RHS_MIN   = {1'b1, {(RHS_W - 1){1'b0}}};
  localparam logic [RHS_W-1:0]   RHS_MAX   = {1'b0, {(RHS_W - 1){1'b1}}};

  // Input request
  typedef struct packed {
    logic                  func;
    logic [PIXEL_BITS-1:0] pixel_u;
    logic [PIXEL_BITS-1:0] pixel_v;
  } in_req_t;

  // Result
  typedef struct packed {
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic                      singular;
  } out_res_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MLOAD,
    ST_MRUN,
    ST_MPOST,
    ST_CHECK,
    ST_DLOAD,
    ST_DCHK,
    ST_DITER,
    ST_DDONE,
    ST_FINISH
  } state_e;

  // Multiply steps, in issue order; plane mode skips T1 through XP2
  typedef enum logic [3:0] {
    STEP_P1,
    STEP_S1,
    STEP_Q1,
    STEP_P2,
    STEP_S2,
    STEP_Q2,
    STEP_T1,
    STEP_T2,
    STEP_XP1,
    STEP_XP2,
    STEP_DET_A,
    STEP_DET_B,
    STEP_NP_A,
    STEP_NP_B,
    STEP_NQ_A,
    STEP_NQ_B
  } step_e;

endpackage

// ----- rtl/laser_line_triangulation_unit.sv -----
// ----------------------------------------------------------------------------
// laser_line_triangulation_unit: 2x2 Cramer solver for laser triangulation
// Builds the linear system from the projection matrix and the pixel, forms
// the determinant and numerators on a 4-bit-per-cycle shift-add multiplier
// and takes the two quotients on a one-bit-per-cycle restoring divider.
// ----------------------------------------------------------------------------
// One request at a time: the 12 (plane) or 16 (point) serial multiplies
//   and the two restoring divisions run in turn; multiplies stop early on
//   small operands and a zero determinant skips both divisions.
// A new request is taken once the result moves into the output register.
// Reset (rst_ni low, async) clears the matrix registers, the stored laser
//   plane X, the sequencer and the output valid.

module laser_line_triangulation_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  llt_pkg::in_req_t                    in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output llt_pkg::out_res_t                   out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [llt_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [llt_pkg::CFG_W-1:0]           cfg_data_i
);

  // Control state
  llt_pkg::state_e state_q, state_d;
  llt_pkg::step_e  step_q, step_d;
  logic [llt_pkg::CFG_W-1:0]          cfg_q [llt_pkg::NUM_CFG];
  logic signed [llt_pkg::COORD_W-1:0] laser_x_q;
  logic                               out_valid_q;
  llt_pkg::out_res_t                  out_data_q;

  // Captured request
  logic                          func_q;
  logic [llt_pkg::PIXEL_BITS-1:0] u_q;
  logic [llt_pkg::PIXEL_BITS-1:0] v_q;

  // Linear terms and right sides
  logic signed [llt_pkg::LIN_W-1:0] p1_q, s1_q, t1_q, q1_q;
  logic signed [llt_pkg::LIN_W-1:0] p2_q, s2_q, t2_q, q2_q;
  logic signed [llt_pkg::RHS_W-1:0] c1_q, c2_q;

  // Serial multiplier
  logic [llt_pkg::PROD_W-1:0]       mcand_q;
  logic [llt_pkg::MPLIER_W-1:0]     mplier_q;
  logic [llt_pkg::PROD_W-1:0]       acc_q;
  logic                             msign_q;
  logic signed [llt_pkg::NUM_W-1:0] prod_q;
  logic signed [llt_pkg::NUM_W-1:0] first_q;
  logic signed [llt_pkg::NUM_W-1:0] det_q, np_q, nq_q;

  // Serial divider
  logic                             sing_q;
  logic [llt_pkg::NUM_W-1:0]        dabs_q;
  logic [llt_pkg::NUM_W-1:0]        nabs_q;
  logic                             dneg_q;
  logic                             ovf_q;
  logic [llt_pkg::NUM_W-1:0]        rem_q;
  logic [llt_pkg::COORD_W-1:0]      qsh_q;
  logic [llt_pkg::DCNT_W-1:0]       cnt_q;
  logic                             div_sel_q;
  logic signed [llt_pkg::COORD_W-1:0] qp_q, qq_q;

  // Combinational
  logic signed [llt_pkg::COEF_W-1:0]   coef [llt_pkg::NUM_COEF];
  logic                                plane;
  logic signed [llt_pkg::LIN_W-1:0]    a1, b1, a2, b2;
  logic signed [llt_pkg::MCAND_W-1:0]  ld_mcand;
  logic signed [llt_pkg::MPLIER_W-1:0] ld_mplier;
  logic [llt_pkg::MCAND_W-1:0]         mcand_mag;
  logic [llt_pkg::MPLIER_W-1:0]        mplier_mag;
  logic                                is_xp;
  logic signed [llt_pkg::COEF_W-1:0]   post_coef;
  logic signed [llt_pkg::NUM_W-1:0]    lin_val, lin_neg;
  logic signed [llt_pkg::LIN_W-1:0]    rhs_sel;
  logic signed [llt_pkg::NUM_W-1:0]    rhs_val;
  logic [llt_pkg::NUM_W-llt_pkg::RHS_W:0] rhs_hi;
  logic signed [llt_pkg::RHS_W-1:0]    rhs_sat;
  logic [llt_pkg::NUM_W-1:0]           prod_ext;
  logic                                det_zero;
  logic [llt_pkg::NUM_W-1:0]           det_mag;
  logic signed [llt_pkg::NUM_W-1:0]    div_num;
  logic [llt_pkg::NUM_W-1:0]           num_mag;
  logic [llt_pkg::NUM_W-1:0]           num_hi;
  logic                                div_ovf;
  logic [llt_pkg::NUM_W:0]             rem2;
  logic                                rem_ge;
  logic [llt_pkg::NUM_W-1:0]           rem_tr;
  logic [llt_pkg::COORD_W-1:0]         quot;
  llt_pkg::out_res_t                   res;
  logic                                out_free;
  logic                                out_load;
  logic                                in_ready;

  // Matrix entries: even entry in the low half of each register
  for (genvar k = 0; k < llt_pkg::NUM_COEF; k++) begin : g_coef
    assign coef[k] = cfg_q[k / 2][(k % 2) * llt_pkg::COEF_W +: llt_pkg::COEF_W];
  end

  assign plane = ~func_q;

  // System coefficients per mode
  always_comb begin
    if (plane) begin
      a1 = p1_q;
      b1 = s1_q;
      a2 = p2_q;
      b2 = s2_q;
    end else begin
      a1 = s1_q;
      b1 = t1_q;
      a2 = s2_q;
      b2 = t2_q;
    end
  end

  // Multiply operand select per step
  always_comb begin
    ld_mcand  = '0;
    ld_mplier = '0;
    post_coef = '0;
    unique case (step_q)
      llt_pkg::STEP_P1: begin
        ld_mcand  = llt_pkg::MCAND_W'(coef[8]);
        ld_mplier = llt_pkg::MPLIER_W'(u_q);
        post_coef = coef[0];
      end
      llt_pkg::STEP_S1: begin
        ld_mcand  = llt_pkg::MCAND_W'(coef[9]);
        ld_mplier = llt_pkg::MPLIER_W'(u_q);
        post_coef = coef[1];
      end
      llt_pkg::STEP_Q1: begin
        ld_mcand  = llt_pkg::MCAND_W'(coef[11]);
        ld_mplier = llt_pkg::MPLIER_W'(u_q);
        post_coef = coef[3];
      end
      llt_pkg::STEP_P2: begin
        ld_mcand  = llt_pkg::MCAND_W'(coef[8]);
        ld_mplier = llt_pkg::MPLIER_W'(v_q);
        post_coef = coef[4];
      end
      llt_pkg::STEP_S2: begin
        ld_mcand  = llt_pkg::MCAND_W'(coef[9]);
        ld_mplier = llt_pkg::MPLIER_W'(v_q);
        post_coef = coef[5];
      end
      llt_pkg::STEP_Q2: begin
        ld_mcand  = llt_pkg::MCAND_W'(coef[11]);
        ld_mplier = llt_pkg::MPLIER_W'(v_q);
        post_coef = coef[7];
      end
      llt_pkg::STEP_T1: begin
        ld_mcand  = llt_pkg::MCAND_W'(coef[10]);
        ld_mplier = llt_pkg::MPLIER_W'(u_q);
        post_coef = coef[2];
      end
      llt_pkg::STEP_T2: begin
        ld_mcand  = llt_pkg::MCAND_W'(coef[10]);
        ld_mplier = llt_pkg::MPLIER_W'(v_q);
        post_coef = coef[6];
      end
      llt_pkg::STEP_XP1: begin
        ld_mcand  = llt_pkg::MCAND_W'(p1_q);
        ld_mplier = llt_pkg::MPLIER_W'(laser_x_q);
      end
      llt_pkg::STEP_XP2: begin
        ld_mcand  = llt_pkg::MCAND_W'(p2_q);
        ld_mplier = llt_pkg::MPLIER_W'(laser_x_q);
      end
      llt_pkg::STEP_DET_A: begin
        ld_mcand  = llt_pkg::MCAND_W'(a1);
        ld_mplier = b2;
      end
      llt_pkg::STEP_DET_B: begin
        ld_mcand  = llt_pkg::MCAND_W'(a2);
        ld_mplier = b1;
      end
      llt_pkg::STEP_NP_A: begin
        ld_mcand  = c1_q;
        ld_mplier = b2;
      end
      llt_pkg::STEP_NP_B: begin
        ld_mcand  = c2_q;
        ld_mplier = b1;
      end
      llt_pkg::STEP_NQ_A: begin
        ld_mcand  = c2_q;
        ld_mplier = a1;
      end
      llt_pkg::STEP_NQ_B: begin
        ld_mcand  = c1_q;
        ld_mplier = a2;
      end
      default: begin
        ld_mcand  = '0;
        ld_mplier = '0;
      end
    endcase
  end

  // Operand magnitudes; X*P steps come out negated for the right side
  assign mcand_mag  = ld_mcand[llt_pkg::MCAND_W-1] ?
                      llt_pkg::MCAND_W'(-ld_mcand) : llt_pkg::MCAND_W'(ld_mcand);
  assign mplier_mag = ld_mplier[llt_pkg::MPLIER_W-1] ?
                      llt_pkg::MPLIER_W'(-ld_mplier) : llt_pkg::MPLIER_W'(ld_mplier);
  assign is_xp      = (step_q == llt_pkg::STEP_XP1) || (step_q == llt_pkg::STEP_XP2);
  assign prod_ext   = llt_pkg::NUM_W'(acc_q);

  // Post-multiply arithmetic
  assign lin_val = prod_q - llt_pkg::NUM_W'(post_coef);
  assign lin_neg = llt_pkg::NUM_W'(post_coef) - prod_q;
  assign rhs_sel = (step_q == llt_pkg::STEP_XP2) ? q2_q : q1_q;
  // floor(-X*P / 2^FRAC) - Q, then clamp to the right-side range
  assign rhs_val = (prod_q >>> llt_pkg::FRAC_BITS) - llt_pkg::NUM_W'(rhs_sel);
  assign rhs_hi  = rhs_val[llt_pkg::NUM_W-1:llt_pkg::RHS_W-1];

  always_comb begin
    if ((&rhs_hi) || ~(|rhs_hi)) begin
      rhs_sat = llt_pkg::RHS_W'(rhs_val);
    end else if (rhs_val[llt_pkg::NUM_W-1]) begin
      rhs_sat = llt_pkg::RHS_MIN;
    end else begin
      rhs_sat = llt_pkg::RHS_MAX;
    end
  end

  // Determinant and numerator magnitudes
  assign det_zero = (det_q == '0);
  assign det_mag  = det_q[llt_pkg::NUM_W-1] ? llt_pkg::NUM_W'(-det_q) : llt_pkg::NUM_W'(det_q);
  assign div_num  = div_sel_q ? nq_q : np_q;
  assign num_mag  = div_num[llt_pkg::NUM_W-1] ?
                    llt_pkg::NUM_W'(-div_num) : llt_pkg::NUM_W'(div_num);

  // Overflow test: quotient reaches 2^COORD_W when the high part is >= divisor
  assign num_hi  = nabs_q >> llt_pkg::QLO_W;
  assign div_ovf = (num_hi >= dabs_q);

  // Restoring divider step
  assign rem2   = {rem_q, qsh_q[llt_pkg::COORD_W-1]};
  assign rem_ge = (rem2 >= {1'b0, dabs_q});
  assign rem_tr = rem_ge ? llt_pkg::NUM_W'(rem2 - {1'b0, dabs_q}) : llt_pkg::NUM_W'(rem2);

  // Signed, saturated quotient
  always_comb begin
    priority if (ovf_q) begin
      quot = dneg_q ? llt_pkg::COORD_MIN : llt_pkg::COORD_MAX;
    end else if (dneg_q) begin
      quot = (qsh_q > llt_pkg::COORD_MIN) ? llt_pkg::COORD_MIN : ('0 - qsh_q);
    end else begin
      quot = qsh_q[llt_pkg::COORD_W-1] ? llt_pkg::COORD_MAX : qsh_q;
    end
  end

  // Result assembly
  always_comb begin
    res.singular = sing_q;
    priority if (sing_q) begin
      res.coord_x = '0;
      res.coord_y = '0;
      res.coord_z = '0;
    end else if (plane) begin
      res.coord_x = qp_q;
      res.coord_y = qq_q;
      res.coord_z = '0;
    end else begin
      res.coord_x = laser_x_q;
      res.coord_y = qp_q;
      res.coord_z = qq_q;
    end
  end

  assign out_free = ~out_valid_q | out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      llt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = llt_pkg::ST_MLOAD;
          step_d  = llt_pkg::STEP_P1;
        end
      end
      llt_pkg::ST_MLOAD: state_d = llt_pkg::ST_MRUN;
      llt_pkg::ST_MRUN: begin
        if (mplier_q == '0) begin
          state_d = llt_pkg::ST_MPOST;
        end
      end
      llt_pkg::ST_MPOST: begin
        if (step_q == llt_pkg::STEP_NQ_B) begin
          state_d = llt_pkg::ST_CHECK;
        end else begin
          state_d = llt_pkg::ST_MLOAD;
          if (plane && (step_q == llt_pkg::STEP_Q2)) begin
            step_d = llt_pkg::STEP_DET_A;
          end else begin
            step_d = llt_pkg::step_e'(step_q + 4'd1);
          end
        end
      end
      llt_pkg::ST_CHECK: state_d = det_zero ? llt_pkg::ST_FINISH : llt_pkg::ST_DLOAD;
      llt_pkg::ST_DLOAD: state_d = llt_pkg::ST_DCHK;
      llt_pkg::ST_DCHK:  state_d = div_ovf ? llt_pkg::ST_DDONE : llt_pkg::ST_DITER;
      llt_pkg::ST_DITER: begin
        if (cnt_q == llt_pkg::DCNT_W'(llt_pkg::COORD_W - 1)) begin
          state_d = llt_pkg::ST_DDONE;
        end
      end
      llt_pkg::ST_DDONE:  state_d = div_sel_q ? llt_pkg::ST_FINISH : llt_pkg::ST_DLOAD;
      llt_pkg::ST_FINISH: begin
        if (out_free) begin
          state_d = llt_pkg::ST_IDLE;
        end
      end
      default: state_d = llt_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs of the sequencer
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      llt_pkg::ST_IDLE:   in_ready = 1'b1;
      llt_pkg::ST_FINISH: out_load = out_free;
      default: begin
        in_ready = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  // Control registers, matrix and stored plane X
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= llt_pkg::ST_IDLE;
      step_q      <= llt_pkg::STEP_P1;
      out_valid_q <= 1'b0;
      laser_x_q   <= '0;
      for (int i = 0; i < llt_pkg::NUM_CFG; i++) begin
        cfg_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      // plane mode latches its X, zero when singular
      if (out_load && plane) begin
        laser_x_q <= res.coord_x;
      end
      // writes past the last register are dropped
      if (cfg_valid_i && (cfg_index_i < llt_pkg::CFG_IDX_W'(llt_pkg::NUM_CFG))) begin
        cfg_q[cfg_index_i] <= cfg_data_i;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      llt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          func_q <= in_data_i.func;
          u_q    <= in_data_i.pixel_u;
          v_q    <= in_data_i.pixel_v;
        end
      end
      llt_pkg::ST_MLOAD: begin
        mcand_q  <= llt_pkg::PROD_W'(mcand_mag);
        mplier_q <= mplier_mag;
        acc_q    <= '0;
        msign_q  <= ld_mcand[llt_pkg::MCAND_W-1] ^ ld_mplier[llt_pkg::MPLIER_W-1] ^ is_xp;
      end
      // one multiplier digit per cycle, done when no digits remain
      llt_pkg::ST_MRUN: begin
        if (mplier_q == '0) begin
          prod_q <= msign_q ? -prod_ext : prod_ext;
        end else begin
          acc_q    <= acc_q + llt_pkg::PROD_W'(mcand_q * mplier_q[llt_pkg::DIG_W-1:0]);
          mcand_q  <= mcand_q << llt_pkg::DIG_W;
          mplier_q <= mplier_q >> llt_pkg::DIG_W;
        end
      end
      llt_pkg::ST_MPOST: begin
        unique case (step_q)
          llt_pkg::STEP_P1: p1_q <= llt_pkg::LIN_W'(lin_val);
          llt_pkg::STEP_S1: s1_q <= llt_pkg::LIN_W'(lin_val);
          llt_pkg::STEP_Q1: begin
            q1_q <= llt_pkg::LIN_W'(lin_val);
            c1_q <= llt_pkg::RHS_W'(lin_neg);
          end
          llt_pkg::STEP_P2: p2_q <= llt_pkg::LIN_W'(lin_val);
          llt_pkg::STEP_S2: s2_q <= llt_pkg::LIN_W'(lin_val);
          llt_pkg::STEP_Q2: begin
            q2_q <= llt_pkg::LIN_W'(lin_val);
            c2_q <= llt_pkg::RHS_W'(lin_neg);
          end
          llt_pkg::STEP_T1:    t1_q    <= llt_pkg::LIN_W'(lin_val);
          llt_pkg::STEP_T2:    t2_q    <= llt_pkg::LIN_W'(lin_val);
          llt_pkg::STEP_XP1:   c1_q    <= rhs_sat;
          llt_pkg::STEP_XP2:   c2_q    <= rhs_sat;
          llt_pkg::STEP_DET_A: first_q <= prod_q;
          llt_pkg::STEP_DET_B: det_q   <= first_q - prod_q;
          llt_pkg::STEP_NP_A:  first_q <= prod_q;
          llt_pkg::STEP_NP_B:  np_q    <= first_q - prod_q;
          llt_pkg::STEP_NQ_A:  first_q <= prod_q;
          llt_pkg::STEP_NQ_B:  nq_q    <= first_q - prod_q;
          default: first_q <= prod_q;
        endcase
      end
      llt_pkg::ST_CHECK: begin
        sing_q    <= det_zero;
        dabs_q    <= det_mag;
        div_sel_q <= 1'b0;
      end
      llt_pkg::ST_DLOAD: begin
        nabs_q <= num_mag;
        dneg_q <= div_num[llt_pkg::NUM_W-1] ^ det_q[llt_pkg::NUM_W-1];
      end
      // high part seeds the remainder, low part and fraction zeros shift in
      llt_pkg::ST_DCHK: begin
        rem_q <= num_hi;
        qsh_q <= {nabs_q[llt_pkg::QLO_W-1:0], {llt_pkg::FRAC_BITS{1'b0}}};
        ovf_q <= div_ovf;
        cnt_q <= '0;
      end
      llt_pkg::ST_DITER: begin
        rem_q <= rem_tr;
        qsh_q <= {qsh_q[llt_pkg::COORD_W-2:0], rem_ge};
        cnt_q <= cnt_q + 1'b1;
      end
      llt_pkg::ST_DDONE: begin
        if (div_sel_q) begin
          qq_q <= quot;
        end else begin
          qp_q <= quot;
        end
        div_sel_q <= 1'b1;
      end
      llt_pkg::ST_FINISH: begin
        if (out_free) begin
          out_data_q <= res;
        end
      end
      default: begin
        cnt_q <= '0;
      end
    endcase
  end

  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign cfg_ready_o = 1'b1;

endmodule

// ----- test/laser_line_triangulation_unit_test.sv -----
// ----------------------------------------------------------------------------
// laser_line_triangulation_unit_test: self-checking bench for the triangulator
// Loads a series of projection matrices over the register port and streams
// plane and point requests through the block, predicting every result with
// wide integer Cramer arithmetic and checking it field by field.
// ----------------------------------------------------------------------------
module laser_line_triangulation_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_ITEMS = 1880;
  localparam int IDLE_PCT     = 9;
  localparam int CALM_FROM    = 800;
  localparam int CALM_TO      = 1100;
  localparam int HOLD_AT      = 310;
  localparam int HOLD_CYCLES  = 1500;
  localparam int DRAIN_CYCLES = 300;
  localparam int REPORT_MAX   = 10;
  localparam int TIMEOUT_NS   = 15_000_000;

  localparam logic FUNC_PLANE = 1'b0;
  localparam logic FUNC_POINT = 1'b1;

  // index values past the last coefficient pair: writes must be dropped
  localparam logic [llt_pkg::CFG_IDX_W-1:0] IDX_SPARE_LO =
    llt_pkg::CFG_IDX_W'(llt_pkg::NUM_CFG);
  localparam logic [llt_pkg::CFG_IDX_W-1:0] IDX_SPARE_HI =
    llt_pkg::CFG_IDX_W'(llt_pkg::NUM_CFG + 1);

  localparam logic [llt_pkg::PIXEL_BITS-1:0] PIXEL_MAX = '1;

  typedef logic signed [159:0] wide_t;
  typedef logic [llt_pkg::CFG_W-1:0] matrix_t [llt_pkg::NUM_CFG];

  localparam wide_t RHS_TOP   = (wide_t'(1) <<< (llt_pkg::RHS_W - 1)) - 1;
  localparam wide_t COORD_TOP = wide_t'(1) <<< (llt_pkg::COORD_W - 1);

  logic                          clk_i     = 1'b0;
  logic                          rst_ni    = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  llt_pkg::in_req_t              in_req    = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  llt_pkg::out_res_t             out_res;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [llt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [llt_pkg::CFG_W-1:0]     cfg_data  = '0;

  // shadow of the block's registers and stored laser plane X
  logic [llt_pkg::CFG_W-1:0]          coeff_regs [llt_pkg::NUM_CFG] = '{default: '0};
  logic signed [llt_pkg::COORD_W-1:0] plane_x = '0;

  llt_pkg::in_req_t  pending_reqs [$];
  llt_pkg::out_res_t expected_res [$];
  int unsigned sent_cnt   = 0;
  int unsigned mismatches = 0;
  int unsigned hold_left  = 0;
  logic        hold_done  = 1'b0;
  int          cam_cx     = -1;
  logic        calm;

  assign calm = (sent_cnt >= CALM_FROM) && (sent_cnt < CALM_TO);

  laser_line_triangulation_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_res),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // signed Q16.16 matrix entry k, widened
  function automatic wide_t coef(int k);
    logic [llt_pkg::CFG_W-1:0]         r;
    logic signed [llt_pkg::COEF_W-1:0] h;
    r = coeff_regs[k / 2];
    h = (k % 2) ? r[llt_pkg::COEF_W +: llt_pkg::COEF_W] : r[0 +: llt_pkg::COEF_W];
    return wide_t'(h);
  endfunction

  // (num << FRAC_BITS) / den, truncated toward zero, saturated to a coordinate
  function automatic logic signed [llt_pkg::COORD_W-1:0] div_sat(wide_t num, wide_t den);
    wide_t n, d, q;
    logic  neg;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = (n <<< llt_pkg::FRAC_BITS) / d;
    if (neg) begin
      if (q > COORD_TOP) return llt_pkg::COORD_MIN;
      q = -q;
      return q[llt_pkg::COORD_W-1:0];
    end
    if (q >= COORD_TOP) return llt_pkg::COORD_MAX;
    return q[llt_pkg::COORD_W-1:0];
  endfunction

  // point-mode right side: (-x*p - q*2^F) >> F, floor, saturated to RHS_W bits
  function automatic wide_t rhs_sat(wide_t x, wide_t p, wide_t q);
    wide_t t;
    t = (-(x * p) - (q <<< llt_pkg::FRAC_BITS)) >>> llt_pkg::FRAC_BITS;
    if (t > RHS_TOP) return RHS_TOP;
    if (t < -RHS_TOP - 1) return -RHS_TOP - 1;
    return t;
  endfunction

  // Cramer's rule on a 2x2 system; returns 1 on a zero determinant
  function automatic logic cramer(input wide_t a1, b1, c1, a2, b2, c2,
                                  output logic signed [llt_pkg::COORD_W-1:0] p, q);
    wide_t det;
    det = a1 * b2 - a2 * b1;
    p = '0;
    q = '0;
    if (det == 0) return 1'b1;
    p = div_sat(c1 * b2 - c2 * b1, det);
    q = div_sat(a1 * c2 - a2 * c1, det);
    return 1'b0;
  endfunction

  // expected result of one request; updates the stored plane X
  function automatic llt_pkg::out_res_t triangulate(llt_pkg::in_req_t req);
    wide_t                              m [llt_pkg::NUM_COEF];
    wide_t                              u, v, c1, c2;
    logic signed [llt_pkg::COORD_W-1:0] s0, s1;
    llt_pkg::out_res_t                  res;
    for (int k = 0; k < llt_pkg::NUM_COEF; k++) m[k] = coef(k);
    u = wide_t'(req.pixel_u);
    v = wide_t'(req.pixel_v);
    res = '0;
    if (req.func == FUNC_PLANE) begin
      // end point on Z=0: solve X and Y, keep X as the plane position
      res.singular = cramer(m[8] * u - m[0], m[9] * u - m[1], m[3] - m[11] * u,
                            m[8] * v - m[4], m[9] * v - m[5], m[7] - m[11] * v, s0, s1);
      res.coord_x = s0;
      res.coord_y = s1;
      plane_x = s0;
    end else begin
      // line point: X known, solve Y and Z
      c1 = rhs_sat(wide_t'(plane_x), u * m[8] - m[0], u * m[11] - m[3]);
      c2 = rhs_sat(wide_t'(plane_x), v * m[8] - m[4], v * m[11] - m[7]);
      res.singular = cramer(u * m[9] - m[1], u * m[10] - m[2], c1,
                            v * m[9] - m[5], v * m[10] - m[6], c2, s0, s1);
      res.coord_x = res.singular ? '0 : plane_x;
      res.coord_y = s0;
      res.coord_z = s1;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    logic holding;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      sent_cnt <= 0;
    end else begin
      holding = in_valid;
      if (in_valid && in_ready) begin
        expected_res = {expected_res, triangulate(in_req)};
        sent_cnt <= sent_cnt + 1;
        holding = 1'b0;
      end
      if (!holding) begin
        if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          in_req   <= pending_reqs.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: ready pattern with one long hold-off
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : accept_proc
    if (!rst_ni) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && sent_cnt >= HOLD_AT && pending_reqs.size() > 2) begin
      // sender keeps offering while results back up
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Result checker
  always @(posedge clk_i) begin : check_proc
    llt_pkg::out_res_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (expected_res.size() == 0) begin
        if (mismatches < REPORT_MAX)
          $display("%0t: result with no request outstanding: x %0d y %0d z %0d singular %0b",
                   $realtime, out_res.coord_x, out_res.coord_y, out_res.coord_z,
                   out_res.singular);
        mismatches++;
      end else begin
        want = expected_res.pop_front();
        if (want.coord_x !== out_res.coord_x || want.coord_y !== out_res.coord_y ||
            want.coord_z !== out_res.coord_z || want.singular !== out_res.singular) begin
          if (mismatches < REPORT_MAX)
            $display("%0t: mismatch (exp/got) x %0d/%0d y %0d/%0d z %0d/%0d singular %0b/%0b",
                     $realtime, want.coord_x, out_res.coord_x, want.coord_y, out_res.coord_y,
                     want.coord_z, out_res.coord_z, want.singular, out_res.singular);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void push_req(logic func, logic [llt_pkg::PIXEL_BITS-1:0] u,
                                   logic [llt_pkg::PIXEL_BITS-1:0] v);
    llt_pkg::in_req_t r;
    r.func    = func;
    r.pixel_u = u;
    r.pixel_v = v;
    pending_reqs = {pending_reqs, r};
  endfunction

  function automatic logic [llt_pkg::PIXEL_BITS-1:0] pick_pixel();
    case ($urandom_range(19))
      0: return '0;
      1: return PIXEL_MAX;
      default: return llt_pkg::PIXEL_BITS'($urandom_range(PIXEL_MAX));
    endcase
  endfunction

  // pinhole camera K[R|t]; fx, fy, cx, cy and tz in whole pixels/units,
  // tx, ty, skew and the perspective terms r0, r1 as raw Q16.16
  function automatic matrix_t camera(int fx, int fy, int cx, int cy, int tx, int ty,
                                     int tz, int skew, int r0, int r1);
    matrix_t mt;
    mt[0] = {32'(skew), 32'(fx <<< llt_pkg::FRAC_BITS)};
    mt[1] = {32'(tx), 32'(cx <<< llt_pkg::FRAC_BITS)};
    mt[2] = {32'(fy <<< llt_pkg::FRAC_BITS), 32'(0)};
    mt[3] = {32'(ty), 32'(cy <<< llt_pkg::FRAC_BITS)};
    mt[4] = {32'(r1), 32'(r0)};
    mt[5] = {32'(tz <<< llt_pkg::FRAC_BITS), 32'(1 <<< llt_pkg::FRAC_BITS)};
    return mt;
  endfunction

  function automatic int small_coef();
    return int'($urandom_range(131072)) - 65536;
  endfunction

  // random matrix: half cameras, the rest small, wide-open or boundary entries
  function automatic matrix_t random_matrix();
    matrix_t     mt;
    int          pick, cx;
    logic        flat;
    logic [31:0] bounds [5];
    bounds = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h1};
    pick = $urandom_range(99);
    cam_cx = -1;
    if (pick < 50) begin
      // flat view: no skew or perspective terms, point mode goes singular at u = cx
      flat = $urandom_range(1);
      cx = $urandom_range(PIXEL_MAX);
      mt = camera($urandom_range(200, 2000), $urandom_range(200, 2000), cx,
                  $urandom_range(PIXEL_MAX), int'($urandom) >>> 4, int'($urandom) >>> 4,
                  $urandom_range(1, 1000), flat ? 0 : int'($urandom_range(2048)) - 1024,
                  flat ? 0 : int'($urandom_range(128)) - 64,
                  flat ? 0 : int'($urandom_range(128)) - 64);
      if (flat) cam_cx = cx;
    end else if (pick < 70) begin
      for (int k = 0; k < llt_pkg::NUM_CFG; k++)
        mt[k] = {32'(small_coef()), 32'(small_coef())};
    end else if (pick < 90) begin
      for (int k = 0; k < llt_pkg::NUM_CFG; k++) mt[k] = {$urandom, $urandom};
    end else begin
      for (int k = 0; k < llt_pkg::NUM_CFG; k++)
        mt[k] = {bounds[$urandom_range(4)], bounds[$urandom_range(4)]};
    end
    return mt;
  endfunction

  // one register write request
  task automatic write_coeff(input logic [llt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [llt_pkg::CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    if (idx < llt_pkg::NUM_CFG) coeff_regs[idx] = val;
    cfg_valid <= 1'b0;
  endtask

  task automatic load_matrix(input matrix_t mt);
    for (int i = 0; i < llt_pkg::NUM_CFG; i++) write_coeff(llt_pkg::CFG_IDX_W'(i), mt[i]);
    if ($urandom_range(3) == 0)
      write_coeff($urandom_range(1) ? IDX_SPARE_HI : IDX_SPARE_LO, {$urandom, $urandom});
    @(negedge clk_i);
  endtask

  // sender pause: nothing queued, nothing offered, nothing outstanding
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || in_valid || expected_res.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus_proc
    matrix_t                        mt;
    int                             made, run_len, n, pts;
    logic [llt_pkg::PIXEL_BITS-1:0] u;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // all-zero matrix after reset: every system is singular
    push_req(FUNC_PLANE, '0, '0);
    push_req(FUNC_POINT, PIXEL_MAX, PIXEL_MAX);
    wait_idle();

    // plain camera; point mode turns singular on the principal column
    load_matrix(camera(800, 800, 2048, 1536, 100 <<< llt_pkg::FRAC_BITS,
                       -(50 <<< llt_pkg::FRAC_BITS), 500, 0, 0, 0));
    push_req(FUNC_PLANE, '0, '0);
    push_req(FUNC_PLANE, PIXEL_MAX, PIXEL_MAX);
    push_req(FUNC_POINT, '0, '0);
    push_req(FUNC_POINT, PIXEL_MAX, PIXEL_MAX);
    push_req(FUNC_POINT, 12'd2048, 12'd100);
    push_req(FUNC_PLANE, 12'd2048, 12'd1536);
    push_req(FUNC_POINT, 12'd1000, 12'd3000);
    push_req(FUNC_POINT, '0, PIXEL_MAX);
    push_req(FUNC_POINT, PIXEL_MAX, '0);
    wait_idle();

    // unit determinant with extreme right sides: X saturates low, Y high
    mt = '{64'h0000_0000_0000_0001, 64'h7FFF_FFFF_0000_0000, 64'h0000_0001_0000_0000,
           64'h8000_0000_0000_0000, 64'h0, 64'h0};
    load_matrix(mt);
    push_req(FUNC_PLANE, '0, '0);
    push_req(FUNC_POINT, PIXEL_MAX, '0);
    push_req(FUNC_PLANE, PIXEL_MAX, PIXEL_MAX);
    wait_idle();

    // full-scale entries of both signs; spare indexes must not land
    mt = '{64'h8000_0000_7FFF_FFFF, 64'h7FFF_FFFF_8000_0000, 64'h7FFF_FFFF_8000_0000,
           64'h8000_0000_7FFF_FFFF, 64'h8000_0000_7FFF_FFFF, 64'h8000_0000_FFFF_FFFF};
    load_matrix(mt);
    write_coeff(IDX_SPARE_LO, '1);
    write_coeff(IDX_SPARE_HI, '1);
    @(negedge clk_i);
    push_req(FUNC_PLANE, PIXEL_MAX, PIXEL_MAX);
    push_req(FUNC_POINT, '0, '0);
    push_req(FUNC_POINT, PIXEL_MAX, PIXEL_MAX);
    push_req(FUNC_PLANE, 12'd1, '0);
    push_req(FUNC_POINT, 12'd2, 12'd3);
    wait_idle();

    // every entry -1: rows are collinear
    mt = '{default: '1};
    load_matrix(mt);
    push_req(FUNC_PLANE, PIXEL_MAX, '0);
    wait_idle();

    // random matrices, mostly one plane request followed by a run of points
    made = 0;
    while (made < RANDOM_ITEMS) begin
      load_matrix(random_matrix());
      run_len = $urandom_range(60, 180);
      n = 0;
      while (n < run_len && made < RANDOM_ITEMS) begin
        if ($urandom_range(99) < 85) begin
          push_req(FUNC_PLANE, pick_pixel(), pick_pixel());
          pts = $urandom_range(1, 8);
          for (int i = 0; i < pts; i++) begin
            u = pick_pixel();
            if (cam_cx >= 0 && $urandom_range(19) == 0) u = llt_pkg::PIXEL_BITS'(cam_cx);
            push_req(FUNC_POINT, u, pick_pixel());
          end
          n += pts + 1;
          made += pts + 1;
        end else begin
          push_req(logic'($urandom_range(1)), pick_pixel(), pick_pixel());
          n++;
          made++;
        end
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_res.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // hang guard
  initial begin : timeout_proc
    #(TIMEOUT_NS);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
